// ----- rtl/xcfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xcfb_pkg
// shared types and constants for the xor checked frame builder
// ----------------------------------------------------------------------------
package xcfb_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    // request kinds carried in the input tuser bit
    localparam logic REQ_START   = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // result slots of a start transaction
    localparam logic [2:0] SLOT_SYNC0 = 3'd0;
    localparam logic [2:0] SLOT_SYNC1 = 3'd1;
    localparam logic [2:0] SLOT_TYPE  = 3'd2;
    localparam logic [2:0] SLOT_LENHI = 3'd3;
    localparam logic [2:0] SLOT_LENLO = 3'd4;
    localparam logic [2:0] SLOT_CSUM  = 3'd5;

    // result slots of a payload transaction
    localparam logic [2:0] SLOT_DATA     = 3'd0;
    localparam logic [2:0] SLOT_DATA_SUM = 3'd1;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] payload_len;
        logic [7:0]  frame_type;
        logic        req_type;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       stray_error;
    } result_t;

endpackage

// ----- rtl/xor_checked_frame_builder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_builder_unit
// serial frame builder: header, pass-through payload, xor checksum byte
// ----------------------------------------------------------------------------
//
// channel   dir  tdata                                   tuser / tlast
// s_axis    in   [7:0] frame_type, [23:8] payload_len,   tuser: req_type
//                [31:24] data_byte
// m_axis    out  [7:0] out_byte                          tuser: [0] frame_end,
//                                                        [1] stray_error;
//                                                        tlast: run_last
//
// a start transaction yields 5 bytes (6 for an empty frame), a payload
// transaction 1 byte (2 on the last byte of a frame), a stray byte 1 result
// the result sequencer in the item register sets the rate, so a payload
// stream runs at one byte per cycle while m_axis is not back-pressured
// an item leaves the item register in the cycle its final result is loaded,
// and the next item can be taken in that same cycle
// reset clears the frame state, the item and output valid flags
// back-pressure on m_axis holds the output register and then the item register
// ----------------------------------------------------------------------------
module xor_checked_frame_builder_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // frame_type, payload_len, data_byte
    input  logic        s_axis_tuser,   // req_type

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [1:0]  m_axis_tuser,   // frame_end, stray_error
    output logic        m_axis_tlast    // run_last
);

    // item register
    xcfb_pkg::in_item_t item_reg;
    xcfb_pkg::in_item_t item_next;
    logic               item_valid_reg;
    logic               item_valid_next;
    logic [2:0]         slot_reg;
    logic [2:0]         slot_next;

    // frame state
    logic               frame_open_reg;
    logic               frame_open_next;
    logic [15:0]        bytes_left_reg;
    logic [15:0]        bytes_left_next;
    logic [7:0]         running_xor_reg;
    logic [7:0]         running_xor_next;

    // output register
    xcfb_pkg::result_t  out_reg;
    xcfb_pkg::result_t  out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    xcfb_pkg::result_t  res;
    logic               s_accept;
    logic               load;
    logic               item_done;
    logic [7:0]         len_hi;
    logic [7:0]         len_lo;
    logic [7:0]         hdr_xor;
    logic [7:0]         data_xor;
    logic [15:0]        left_dec;
    logic               len_zero;
    logic               last_byte;

    assign len_hi    = item_reg.payload_len[15:8];
    assign len_lo    = item_reg.payload_len[7:0];
    assign len_zero  = (item_reg.payload_len == 16'd0);
    assign hdr_xor   = item_reg.frame_type ^ len_hi ^ len_lo;
    assign data_xor  = running_xor_reg ^ item_reg.data_byte;
    assign left_dec  = bytes_left_reg - 16'd1;
    assign last_byte = (left_dec == 16'd0);

    // result for the current slot of the held item
    always_comb
    begin
        res = '0;
        case (item_reg.req_type)
            xcfb_pkg::REQ_START:
            begin
                case (slot_reg)
                    xcfb_pkg::SLOT_SYNC0:
                    begin
                        res.out_byte = xcfb_pkg::SYNC_BYTE;
                    end
                    xcfb_pkg::SLOT_SYNC1:
                    begin
                        res.out_byte = xcfb_pkg::SYNC_BYTE;
                    end
                    xcfb_pkg::SLOT_TYPE:
                    begin
                        res.out_byte = item_reg.frame_type;
                    end
                    xcfb_pkg::SLOT_LENHI:
                    begin
                        res.out_byte = len_hi;
                    end
                    xcfb_pkg::SLOT_LENLO:
                    begin
                        res.out_byte = len_lo;
                        res.run_last = !len_zero;
                    end
                    default:
                    begin
                        // checksum of an empty frame
                        res.out_byte  = hdr_xor;
                        res.run_last  = 1'b1;
                        res.frame_end = 1'b1;
                    end
                endcase
            end
            default:
            begin
                if (!frame_open_reg)
                begin
                    // stray payload byte, dropped
                    res.run_last    = 1'b1;
                    res.stray_error = 1'b1;
                end
                else if (slot_reg == xcfb_pkg::SLOT_DATA)
                begin
                    res.out_byte = item_reg.data_byte & xcfb_pkg::BYTE_MASK;
                    res.run_last = !last_byte;
                end
                else
                begin
                    // checksum after the last payload byte
                    res.out_byte  = data_xor;
                    res.run_last  = 1'b1;
                    res.frame_end = 1'b1;
                end
            end
        endcase
    end

    assign load          = item_valid_reg && (!out_valid_reg || m_axis_tready);
    assign item_done     = load && res.run_last;
    assign s_axis_tready = !item_valid_reg || item_done;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        item_next.req_type    = s_axis_tuser;
        item_next.frame_type  = s_axis_tdata[7:0];
        item_next.payload_len = s_axis_tdata[23:8];
        item_next.data_byte   = s_axis_tdata[31:24];

        item_valid_next  = item_valid_reg;
        slot_next        = slot_reg;
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_xor_next = running_xor_reg;
        out_next         = res;
        out_valid_next   = out_valid_reg;

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (item_done)
        begin
            item_valid_next = 1'b0;
            slot_next       = 3'd0;
        end
        else if (load)
        begin
            slot_next = slot_reg + 3'd1;
        end

        if (s_accept)
        begin
            item_valid_next = 1'b1;
        end

        // frame state moves once the last result of the transaction is loaded
        if (item_done)
        begin
            if (item_reg.req_type == xcfb_pkg::REQ_START)
            begin
                running_xor_next = hdr_xor;
                frame_open_next  = !len_zero;
                bytes_left_next  = item_reg.payload_len;
            end
            else if (frame_open_reg)
            begin
                running_xor_next = data_xor;
                bytes_left_next  = left_dec;
                frame_open_next  = !last_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            slot_reg        <= 3'd0;
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 16'd0;
            running_xor_reg <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            item_valid_reg  <= item_valid_next;
            slot_reg        <= slot_next;
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_xor_reg <= running_xor_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            item_reg <= item_next;
        end
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg.out_byte;
    assign m_axis_tlast    = out_reg.run_last;
    assign m_axis_tuser[0] = out_reg.frame_end;
    assign m_axis_tuser[1] = out_reg.stray_error;

    // a held item that is not finished keeps its contents
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !item_done |=> item_valid_reg && $stable(item_reg))
        else $error("item register changed before its last result");

    // slot never runs past the checksum of an empty frame
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= xcfb_pkg::SLOT_CSUM)
        else $error("result slot out of range");

    // a checksum or error result always closes the transaction
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.frame_end || out_reg.stray_error) |-> out_reg.run_last)
        else $error("checksum or error result without tlast");

    // an error result carries a zero byte and no checksum flag
    a_stray_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.stray_error |-> out_reg.out_byte == 8'd0 && !out_reg.frame_end)
        else $error("error result with nonzero byte");

    // an open frame always expects at least one more byte
    a_open_left: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> bytes_left_reg != 16'd0)
        else $error("open frame with no bytes left");

endmodule
